@@ rtl/multikey_shell_sort_defines.svh @@
// Assertion macros shared by the shell sort checker.
`ifndef MULTIKEY_SHELL_SORT_DEFINES_SVH
`define MULTIKEY_SHELL_SORT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MSS_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MSS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mss_pkg.sv @@
// Shared types, constants and the record compare function of the shell sort.
`timescale 1ns / 1ps

package mss_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int RECORD_BYTES    = 8;
    localparam int REC_W           = 64;
    localparam int OUT_TDATA_W     = 88;
    localparam int CFG_AW          = 5;

    // Gap update: gap * GAP_MUL / GAP_DIV
    localparam logic [16:0] GAP_MUL = 17'd100000;
    localparam logic [18:0] GAP_DIV = 19'd314159;

    // Reciprocal of the gap scale, rounded up; floor(gap * GAP_RECIP >> GAP_SHIFT)
    // equals the exact quotient for every gap up to 1024
    localparam int          GAP_SHIFT = 29;
    localparam logic [27:0] GAP_RECIP = 28'((((64'd1 << GAP_SHIFT) * 64'(GAP_MUL))
                                             + 64'(GAP_DIV) - 64'd1) / 64'(GAP_DIV));

    // Register indexes
    localparam logic [2:0] REG_KEY_COUNT = 3'd0;
    localparam logic [2:0] REG_KEY_ONE   = 3'd1;
    localparam logic [2:0] REG_KEY_TWO   = 3'd2;
    localparam logic [2:0] REG_KEY_THREE = 3'd3;
    localparam logic [2:0] REG_KEY_FOUR  = 3'd4;

    typedef logic [3:0][6:0] key_desc_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic gap_load;
        logic div_start;
        logic div_step;
        logic rd_p;
        logic cap_v;
        logic rd_prev;
        logic cmp;
        logic move;
        logic fix;
        logic emit_init;
        logic rd_k;
        logic emit;
        logic clear;
    } mss_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic gap_gt1;
        logic div_last;
        logic p_lt_n;
        logic pos_ge_gap;
        logic cmp_le;
        logic out_free;
        logic k_last;
    } mss_sts_t;

    // 1 when record ra compares at or below record rb under the keys
    function automatic logic record_le(logic [REC_W-1:0] ra, logic [REC_W-1:0] rb,
                                       logic [2:0] kc, key_desc_t kd);
        logic [REC_W-1:0] mask;
        logic [3:0]       klt;
        logic [3:0]       kgt;
        logic [3:0]       st;
        logic [3:0]       en;
        logic [2:0]       n;
        logic             lt;
        logic             gt;
        logic             done;
        // per-key magnitude compare over the masked byte range
        for (int k = 0; k < 4; k++) begin
            st   = {1'b0, kd[k][2:0]};
            en   = st + {1'b0, kd[k][5:3]} + 4'd1;
            mask = '0;
            for (int j = 0; j < 8; j++) begin
                if (4'(j) >= st && 4'(j) < en && j < RECORD_BYTES) begin
                    mask[REC_W-1-8*j -: 8] = 8'hFF;
                end
            end
            lt = (ra & mask) < (rb & mask);
            gt = (ra & mask) > (rb & mask);
            klt[k] = kd[k][6] ? gt : lt;
            kgt[k] = kd[k][6] ? lt : gt;
        end
        // first differing key decides
        n    = (kc > 3'd4) ? 3'd4 : kc;
        gt   = 1'b0;
        done = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < n && !done && (klt[k] || kgt[k])) begin
                gt   = kgt[k];
                done = 1'b1;
            end
        end
        return !gt;
    endfunction

endpackage

@@ rtl/multikey_shell_sort.sv @@
// Load: items are stored up to MAX_RECORDS; the sort starts after the last item.
// Sort: a key compare reads the earlier record, registers the result, then moves it;
// an insertion adds a read, capture and fix-up write; a gap update, check and divide.
// Emission: one memory read per item, stalled by m_tready; input held off until done.
// Reset: rst_n asynchronous, active low; clears counters, state and config registers
// (key_count 1, key_one 56, others 0). The record memory is not cleared.
`timescale 1ns / 1ps

module multikey_shell_sort #(
    parameter int MAX_RECORDS = mss_pkg::MAX_RECORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_tdata: record_value[63:0]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mss_pkg::REC_W-1:0]        s_tdata,
    input  logic                             s_tlast,
    // m_tdata: sorted_record[63:0], pass_count[67:64], move_count[83:68],
    // overflow[84], zero[87:85]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mss_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mss_pkg::CFG_AW-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import mss_pkg::*;

    logic [2:0]       kc_reg;
    key_desc_t        kd_reg;
    logic [2:0]       reg_idx;
    mss_cmd_t         cmd;
    mss_sts_t         sts;
    logic [REC_W-1:0] out_rec;
    logic [3:0]       out_passes;
    logic [15:0]      out_moves;
    logic             out_ovf;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kc_reg <= 3'd1;
            kd_reg <= {7'd0, 7'd0, 7'd0, 7'd56};
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_KEY_COUNT: kc_reg    <= pwdata[2:0];
                REG_KEY_ONE:   kd_reg[0] <= pwdata[6:0];
                REG_KEY_TWO:   kd_reg[1] <= pwdata[6:0];
                REG_KEY_THREE: kd_reg[2] <= pwdata[6:0];
                REG_KEY_FOUR:  kd_reg[3] <= pwdata[6:0];
                default:       ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx)
            REG_KEY_COUNT: prdata = {29'd0, kc_reg};
            REG_KEY_ONE:   prdata = {25'd0, kd_reg[0]};
            REG_KEY_TWO:   prdata = {25'd0, kd_reg[1]};
            REG_KEY_THREE: prdata = {25'd0, kd_reg[2]};
            REG_KEY_FOUR:  prdata = {25'd0, kd_reg[3]};
            default:       prdata = 32'd0;
        endcase
    end

    mss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mss_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_rec     (s_tdata),
        .key_count  (kc_reg),
        .key_desc   (kd_reg),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_rec    (out_rec),
        .out_last   (m_tlast),
        .out_passes (out_passes),
        .out_moves  (out_moves),
        .out_ovf    (out_ovf)
    );

    assign m_tdata = {3'd0, out_ovf, out_moves, out_passes, out_rec};

endmodule

@@ rtl/mss_ctrl.sv @@
// Sequencer for load, gap passes, gapped insertion and emission.
`timescale 1ns / 1ps

module mss_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  mss_pkg::mss_sts_t sts,
    output mss_pkg::mss_cmd_t cmd
);
    import mss_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_CHK,
        ST_DIV,
        ST_PLOOP,
        ST_PWAIT,
        ST_ILOOP,
        ST_IWAIT,
        ST_IDEC,
        ST_FIX,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    assign s_tready = ready_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && ready_reg) begin
                    cmd.load = 1'b1;
                    if (s_tlast) state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.gap_load = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.gap_gt1) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_PLOOP;
            end
            ST_PLOOP:
            begin
                if (sts.p_lt_n) begin
                    cmd.rd_p   = 1'b1;
                    state_next = ST_PWAIT;
                end else begin
                    state_next = ST_CHK;
                end
            end
            ST_PWAIT:
            begin
                cmd.cap_v  = 1'b1;
                state_next = ST_ILOOP;
            end
            ST_ILOOP:
            begin
                if (sts.pos_ge_gap) begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_IWAIT;
                end else begin
                    state_next = ST_FIX;
                end
            end
            ST_IWAIT:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_IDEC;
            end
            ST_IDEC:
            begin
                if (sts.cmp_le) begin
                    cmd.move   = 1'b1;
                    state_next = ST_ILOOP;
                end else begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_PLOOP;
            end
            ST_EMIT_RD:
            begin
                cmd.rd_k   = 1'b1;
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.k_last ? ST_DONE : ST_EMIT_RD;
                end
            end
            ST_DONE:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign ready_next = (state_next == ST_LOAD);

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_LOAD;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

@@ rtl/mss_dp.sv @@
// Record memory, counters, gap scaler, key compare and output register.
`timescale 1ns / 1ps

module mss_dp #(
    parameter int MAX_RECORDS = mss_pkg::MAX_RECORDS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mss_pkg::mss_cmd_t        cmd,
    output mss_pkg::mss_sts_t        sts,
    input  logic [mss_pkg::REC_W-1:0] in_rec,
    input  logic [2:0]               key_count,
    input  mss_pkg::key_desc_t       key_desc,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [mss_pkg::REC_W-1:0] out_rec,
    output logic                     out_last,
    output logic [3:0]               out_passes,
    output logic [15:0]              out_moves,
    output logic                     out_ovf
);
    import mss_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = $clog2(MAX_RECORDS);
    localparam int PW = CW + GAP_SHIFT;

    logic [REC_W-1:0] mem [MAX_RECORDS];
    logic [REC_W-1:0] rd_data_reg;
    logic [REC_W-1:0] v_reg, t_reg;
    logic             cmp_le_reg;
    logic [CW-1:0]    count_reg, gap_reg, p_reg, pos_reg, k_reg;
    logic [PW-1:0]    prod_reg;
    logic [3:0]       passes_reg;
    logic [15:0]      moves_reg;
    logic             dropped_reg;
    logic             out_valid_reg, out_last_reg, out_ovf_reg;
    logic [REC_W-1:0] out_rec_reg;
    logic [3:0]       out_passes_reg;
    logic [15:0]      out_moves_reg;

    logic             room;
    logic [CW-1:0]    pos_prev;
    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [REC_W-1:0] wr_data;
    logic [CW-1:0]    q_upd, gap_new;
    logic             fix_write;

    assign room      = count_reg < CW'(MAX_RECORDS);
    assign pos_prev  = pos_reg - gap_reg;
    assign fix_write = cmd.fix && (pos_reg != p_reg);

    // Status
    assign sts.gap_gt1    = gap_reg > CW'(1);
    assign sts.div_last   = 1'b1;
    assign sts.p_lt_n     = p_reg < count_reg;
    assign sts.pos_ge_gap = pos_reg >= gap_reg;
    assign sts.cmp_le     = cmp_le_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.k_last     = (CW'(k_reg + CW'(1)) == count_reg);

    // Memory port selection
    assign rd_en   = cmd.rd_p || cmd.rd_prev || cmd.rd_k;
    assign rd_addr = cmd.rd_p    ? p_reg[AW-1:0]    :
                     cmd.rd_prev ? pos_prev[AW-1:0] : k_reg[AW-1:0];
    assign wr_en   = (cmd.load && room) || cmd.move || fix_write;
    assign wr_addr = cmd.load ? count_reg[AW-1:0] : pos_reg[AW-1:0];
    assign wr_data = cmd.load ? in_rec : (cmd.move ? t_reg : v_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // Gap scaling by reciprocal multiply: product registered, then shifted down
    assign q_upd   = prod_reg[GAP_SHIFT +: CW];
    assign gap_new = (q_upd == '0) ? CW'(1) : q_upd;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_v) v_reg <= rd_data_reg;
        if (cmd.cmp) begin
            t_reg      <= rd_data_reg;
            cmp_le_reg <= record_le(v_reg, rd_data_reg, key_count, key_desc);
        end
        if (cmd.div_start) begin
            prod_reg <= PW'(gap_reg) * PW'(GAP_RECIP);
        end
        if (cmd.emit) begin
            out_rec_reg    <= rd_data_reg;
            out_last_reg   <= sts.k_last;
            out_passes_reg <= passes_reg;
            out_moves_reg  <= moves_reg;
            out_ovf_reg    <= dropped_reg;
        end
    end

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            gap_reg       <= '0;
            p_reg         <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            passes_reg    <= '0;
            moves_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (room) count_reg <= count_reg + CW'(1);
                else      dropped_reg <= 1'b1;
            end
            if (cmd.gap_load) gap_reg <= count_reg;
            if (cmd.div_start && passes_reg != 4'hF) passes_reg <= passes_reg + 4'd1;
            if (cmd.div_step) begin
                gap_reg <= gap_new;
                p_reg   <= gap_new;
            end
            if (cmd.rd_p) pos_reg <= p_reg;
            if (cmd.move) pos_reg <= pos_prev;
            if ((cmd.move || fix_write) && moves_reg != 16'hFFFF) begin
                moves_reg <= moves_reg + 16'd1;
            end
            if (cmd.fix) p_reg <= p_reg + CW'(1);
            if (cmd.emit_init) k_reg <= '0;
            if (cmd.emit) k_reg <= k_reg + CW'(1);
            if (cmd.emit) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            if (cmd.clear) begin
                count_reg   <= '0;
                gap_reg     <= '0;
                passes_reg  <= '0;
                moves_reg   <= '0;
                dropped_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_rec    = out_rec_reg;
    assign out_last   = out_last_reg;
    assign out_passes = out_passes_reg;
    assign out_moves  = out_moves_reg;
    assign out_ovf    = out_ovf_reg;

endmodule

@@ rtl/mss_checker.sv @@
// Port-level checks for the shell sort, bound to the top level.
`timescale 1ns / 1ps
`include "multikey_shell_sort_defines.svh"

module mss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tlast
);
    // Stalled result holds
    `MSS_CHECK_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped")
    `MSS_CHECK_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata moved")
    // No loading while a data set is still being emitted
    `MSS_CHECK(a_no_load_mid_set, m_tvalid && !m_tlast, !s_tready, "ready during emit")
    // Pass count, move count and overflow stay fixed across one data set
    `MSS_CHECK_NEXT(a_set_stats, m_tvalid && m_tready && !m_tlast,
        !m_tvalid || (m_tdata[84:64] == $past(m_tdata[84:64])), "set stats changed")
endmodule

bind multikey_shell_sort mss_checker u_mss_checker (.*);
